/* rtl/lgbl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgbl_pkg: shared types and constants of the log grid bilinear lookup
// Transaction structs, command and register codes, table geometry and the
// fixed-point constants of the exponential.
// ----------------------------------------------------------------------------
package lgbl_pkg;

    localparam int MAX_U_POINTS  = 256;
    localparam int MAX_G2_POINTS = 128;
    localparam int ROW_W         = $clog2(MAX_U_POINTS);
    localparam int COL_W         = $clog2(MAX_G2_POINTS);
    localparam int BANK_AW       = ROW_W + COL_W - 2;
    localparam int BANK_DEPTH    = (MAX_U_POINTS * MAX_G2_POINTS) / 4;

    localparam int VAL_W   = 24;
    localparam int STEP_W  = 23;
    localparam int W_W     = 17;
    localparam int DIV_LAT = 24;

    localparam logic [W_W-1:0] W_ONE     = 17'd65536;
    localparam logic [30:0]    LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0]    LN2_Q30   = 30'd744261118;
    localparam logic [30:0]    ONE_Q30   = 31'h4000_0000;
    localparam logic [23:0]    MASK24    = 24'hFF_FFFF;
    localparam int             HORNER_TERMS = 9;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_G2_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_U_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_U_PTS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_G2_PTS  = 3'd4;

    typedef struct packed {
        logic                    command;
        logic [ROW_W-1:0]        entry_row;
        logic [COL_W-1:0]        entry_col;
        logic signed [VAL_W-1:0] entry_value;
        logic signed [23:0]      log_u;
        logic signed [23:0]      log_gamma2;
    } t_item;

    typedef struct packed {
        logic [23:0] gaunt_value;
        logic        out_of_range;
    } t_result;

    typedef struct packed {
        logic [7:0]     idx;
        logic [W_W-1:0] w;
    } t_loc;

    // Upper cell index and Q1.16 weight from the quotient offset*2^16/step.
    // Exact nonzero multiples of the step land on the upper corner of the lower cell.
    function automatic t_loc locate(input logic [23:0] quot, input logic exact);
        t_loc l;
        if (exact) begin
            if (quot[23:16] == 8'd0) begin
                l.idx = 8'd1;
                l.w   = '0;
            end else begin
                l.idx = quot[23:16];
                l.w   = W_ONE;
            end
        end else begin
            l.idx = quot[23:16] + 8'd1;
            l.w   = {1'b0, quot[15:0]};
        end
        return l;
    endfunction

endpackage

/* rtl/lgbl_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgbl_div: pipelined restoring divider
// Computes floor(offset * 2^16 / step), one quotient bit per stage, and flags
// an offset that is an exact multiple of the step. The offset must stay below 256 steps.
// ----------------------------------------------------------------------------
module lgbl_div import lgbl_pkg::*; (
    input  logic              i_clk,
    input  logic [23:0]       i_off,
    input  logic [STEP_W-1:0] i_step,
    output logic [23:0]       o_quot,
    output logic              o_exact
);

    logic [23:0] r_rem  [DIV_LAT];
    logic [23:0] r_word [DIV_LAT];
    logic [23:0] n_rem  [DIV_LAT];
    logic [23:0] n_word [DIV_LAT];

    // The word shifts the low dividend bits out and the quotient bits in.
    always_comb begin
        logic [23:0] src_rem;
        logic [23:0] src_word;
        logic [23:0] sh;
        logic        ge;
        for (int k = 0; k < DIV_LAT; k++) begin
            if (k == 0) begin
                src_rem  = {8'd0, i_off[23:8]};
                src_word = {i_off[7:0], 16'd0};
            end else begin
                src_rem  = r_rem[k-1];
                src_word = r_word[k-1];
            end
            sh        = {src_rem[22:0], src_word[23]};
            ge        = (sh >= {1'b0, i_step});
            n_rem[k]  = ge ? (sh - {1'b0, i_step}) : sh;
            n_word[k] = {src_word[22:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_LAT; k++) begin
            r_rem[k]  <= n_rem[k];
            r_word[k] <= n_word[k];
        end
    end

    assign o_quot  = r_word[DIV_LAT-1];
    assign o_exact = (r_rem[DIV_LAT-1] == 24'd0) && (r_word[DIV_LAT-1][15:0] == 16'd0);

endmodule

/* rtl/lgbl_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgbl_table: four-bank log factor table
// Banks split rows and columns by parity so that the four corners of a cell
// come from four banks in one cycle. One write and one cell read per cycle.
// ----------------------------------------------------------------------------
module lgbl_table import lgbl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [ROW_W-1:0]        i_wr_row,
    input  logic [COL_W-1:0]        i_wr_col,
    input  logic signed [VAL_W-1:0] i_wr_value,
    input  logic [ROW_W-1:0]        i_rd_row,
    input  logic [COL_W-1:0]        i_rd_col,
    output logic signed [VAL_W-1:0] o_f00,
    output logic signed [VAL_W-1:0] o_f01,
    output logic signed [VAL_W-1:0] o_f10,
    output logic signed [VAL_W-1:0] o_f11
);

    logic signed [VAL_W-1:0] r_rd [4];
    logic                    r_rp;
    logic                    r_cp;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic RP = 1'(b / 2);
        localparam logic CP = 1'(b % 2);

        logic signed [VAL_W-1:0] mem [BANK_DEPTH];
        logic [ROW_W-1:0]        rd_row;
        logic [COL_W-1:0]        rd_col;
        logic                    wr_sel;

        // Of the two rows of the cell, this bank holds the one of its parity.
        always_comb begin
            rd_row = (i_rd_row[0] == RP) ? i_rd_row : (i_rd_row - 1'b1);
            rd_col = (i_rd_col[0] == CP) ? i_rd_col : (i_rd_col - 1'b1);
            wr_sel = i_we && (i_wr_row[0] == RP) && (i_wr_col[0] == CP);
        end

        always_ff @(posedge i_clk) begin
            if (wr_sel) begin
                mem[{i_wr_row[ROW_W-1:1], i_wr_col[COL_W-1:1]}] <= i_wr_value;
            end
            r_rd[b] <= mem[{rd_row[ROW_W-1:1], rd_col[COL_W-1:1]}];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rp <= i_rd_row[0];
        r_cp <= i_rd_col[0];
    end

    assign o_f00 = r_rd[{~r_rp, ~r_cp}];
    assign o_f01 = r_rd[{~r_rp,  r_cp}];
    assign o_f10 = r_rd[{ r_rp, ~r_cp}];
    assign o_f11 = r_rd[{ r_rp,  r_cp}];

endmodule

/* rtl/lgbl_exp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgbl_exp: pipelined fixed-point exponential
// Splits L*log2(e) into an integer power and a fraction, evaluates exp of the
// fraction by a nine-term Horner chain, then scales, rounds and saturates.
// ----------------------------------------------------------------------------
module lgbl_exp import lgbl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_oor,
    input  logic signed [23:0] i_log,
    output logic               o_valid,
    output t_result            o_result
);

    localparam int HSTG = 3 * HORNER_TERMS;

    typedef struct packed {
        logic               oor;
        logic signed [9:0]  k;
        logic [29:0]        r;
    } t_hside;

    logic               r_e1_valid;
    logic               r_e1_oor;
    logic signed [55:0] r_y;
    logic               r_e2_valid;
    logic               r_e2_oor;
    logic signed [9:0]  r_e2_k;
    logic [61:0]        r_p;

    logic   r_hv [HSTG];
    t_hside r_hs [HSTG];

    logic [60:0] r_prod [HORNER_TERMS];
    logic [30:0] r_v    [HORNER_TERMS];
    logic [65:0] r_qm   [HORNER_TERMS];
    logic [30:0] r_e    [HORNER_TERMS];

    logic        r_valid;
    t_result     r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_valid <= 1'b0;
            r_e2_valid <= 1'b0;
            r_valid    <= 1'b0;
            for (int t = 0; t < HSTG; t++) begin
                r_hv[t] <= 1'b0;
            end
        end else begin
            r_e1_valid <= i_valid;
            r_e2_valid <= r_e1_valid;
            r_hv[0]    <= r_e2_valid;
            for (int t = 1; t < HSTG; t++) begin
                r_hv[t] <= r_hv[t-1];
            end
            r_valid <= r_hv[HSTG-1];
        end
    end

    // y = L*log2(e) in Q.46; k is its floor, the next 32 bits its fraction.
    always_ff @(posedge i_clk) begin
        r_e1_oor <= i_oor;
        r_y      <= i_log * $signed({1'b0, LOG2E_Q30});
        r_e2_oor <= r_e1_oor;
        r_e2_k   <= r_y[55:46];
        r_p      <= 62'(r_y[45:14]) * 62'(LN2_Q30);
        r_hs[0]  <= '{oor: r_e2_oor, k: r_e2_k, r: r_p[61:32]};
        for (int t = 1; t < HSTG; t++) begin
            r_hs[t] <= r_hs[t-1];
        end
    end

    for (genvar j = 0; j < HORNER_TERMS; j++) begin : g_term
        localparam int          N = HORNER_TERMS - j;
        localparam logic [34:0] M = 35'((64'd1 << 34) / N);

        logic [30:0] e_in;
        logic [29:0] r_in;
        logic [30:0] q0;
        logic [34:0] rem;
        logic [30:0] q;

        if (j == 0) begin : g_head
            assign e_in = ONE_Q30;
            assign r_in = r_p[61:32];
        end else begin : g_body
            assign e_in = r_e[j-1];
            assign r_in = r_hs[3*j-1].r;
        end

        always_comb begin
            // Reciprocal estimate is low by at most one; one compare fixes it.
            q0  = r_qm[j][64:34];
            rem = 35'(r_v[j]) - 35'(q0) * 35'(N);
            q   = (rem >= 35'(N)) ? (q0 + 31'd1) : q0;
        end

        always_ff @(posedge i_clk) begin
            r_prod[j] <= 61'(e_in) * 61'(r_in);
            r_v[j]    <= r_prod[j][60:30];
            r_qm[j]   <= 66'(r_prod[j][60:30]) * 66'(M);
            r_e[j]    <= ONE_Q30 + q;
        end
    end

    // Scale by 2^k and round half up; powers of eight and more saturate.
    always_ff @(posedge i_clk) begin
        logic signed [9:0] k;
        logic signed [9:0] sm1;
        logic [30:0]       t;
        logic [24:0]       res;
        k   = r_hs[HSTG-1].k;
        sm1 = 10'sd13 - k;
        t   = r_e[HORNER_TERMS-1] >> sm1[4:0];
        res = 25'((32'(t) + 32'd1) >> 1);
        if (r_hs[HSTG-1].oor) begin
            r_result <= '{gaunt_value: 24'd0, out_of_range: 1'b1};
        end else if (k >= 10'sd8) begin
            r_result <= '{gaunt_value: MASK24, out_of_range: 1'b0};
        end else if (k <= -10'sd18) begin
            r_result <= '{gaunt_value: 24'd0, out_of_range: 1'b0};
        end else if (res > 25'(MASK24)) begin
            r_result <= '{gaunt_value: MASK24, out_of_range: 1'b0};
        end else begin
            r_result <= '{gaunt_value: res[23:0], out_of_range: 1'b0};
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* rtl/log_grid_bilinear_gaunt_lookup_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_grid_bilinear_gaunt_lookup_core: bilinear log-table lookup with exp
// Range check, cell search by pipelined division, four-bank table read,
// bilinear blend and fixed-point exponential, all in one pipeline.
// ----------------------------------------------------------------------------
// Table writes take effect at the table stage, in command order.
// Throughput: one command per cycle; o_busy never rises. The 24-stage
// divider and the 27-stage Horner chain make up most of the pipeline.
// Reset: synchronous and active low; registers return to their reset values
// and the pipeline empties. Table contents are undefined until written.
// Results cannot be stalled: each one is presented for exactly one cycle.
module log_grid_bilinear_gaunt_lookup_core import lgbl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_item                i_item,
    output logic                 o_done,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0]          i_cfg_data
);

    typedef struct packed {
        logic                    cmd;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    oor;
    } t_side;

    // Configuration registers.
    logic signed [23:0] r_g2_min;
    logic signed [23:0] r_u_min;
    logic [STEP_W-1:0]  r_step;
    logic [8:0]         r_u_pts;
    logic [7:0]         r_g2_pts;

    logic [STEP_W-1:0]  step_eff;
    logic [ROW_W-1:0]   nu_m1;
    logic [COL_W-1:0]   ng_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g2_min <= -24'sd393216;
            r_u_min  <= -24'sd1048576;
            r_step   <= 23'd13107;
            r_u_pts  <= 9'd146;
            r_g2_pts <= 8'd81;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_G2_MIN: r_g2_min <= i_cfg_data;
                CFG_U_MIN:  r_u_min  <= i_cfg_data;
                CFG_STEP:   r_step   <= i_cfg_data[STEP_W-1:0];
                CFG_U_PTS:  r_u_pts  <= i_cfg_data[8:0];
                CFG_G2_PTS: r_g2_pts <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        step_eff = (r_step == '0) ? 23'd1 : r_step;
        if (r_u_pts < 9'd2) begin
            nu_m1 = 8'd1;
        end else if (r_u_pts > 9'(MAX_U_POINTS)) begin
            nu_m1 = 8'(MAX_U_POINTS - 1);
        end else begin
            nu_m1 = 8'(r_u_pts - 9'd1);
        end
        if (r_g2_pts < 8'd2) begin
            ng_m1 = 7'd1;
        end else if (r_g2_pts > 8'(MAX_G2_POINTS)) begin
            ng_m1 = 7'(MAX_G2_POINTS - 1);
        end else begin
            ng_m1 = 7'(r_g2_pts - 8'd1);
        end
    end

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Input register and range-check stage.
    logic               r_s0_valid;
    t_item              r_s0;
    logic               r_s1_valid;
    t_item              r_s1;
    logic signed [24:0] r_s1_off_u;
    logic signed [24:0] r_s1_off_g;
    logic [30:0]        r_s1_pu;
    logic [29:0]        r_s1_pg;
    t_side              s1_side;

    always_ff @(posedge i_clk) begin
        r_s0       <= i_item;
        r_s1       <= r_s0;
        r_s1_off_u <= 25'(r_s0.log_u) - 25'(r_u_min);
        r_s1_off_g <= 25'(r_s0.log_gamma2) - 25'(r_g2_min);
        r_s1_pu    <= 31'(nu_m1) * 31'(step_eff);
        r_s1_pg    <= 30'(ng_m1) * 30'(step_eff);
    end

    always_comb begin
        s1_side.cmd   = r_s1.command;
        s1_side.row   = r_s1.entry_row;
        s1_side.col   = r_s1.entry_col;
        s1_side.value = r_s1.entry_value;
        s1_side.oor   = r_s1_off_u[24] || r_s1_off_g[24]
                     || (31'(r_s1_off_u[23:0]) > r_s1_pu)
                     || (30'(r_s1_off_g[23:0]) > r_s1_pg);
    end

    // Cell search: both axes divide in parallel while the rest travels along.
    logic [23:0] q_u;
    logic [23:0] q_g;
    logic        ex_u;
    logic        ex_g;

    lgbl_div u_div_u (
        .i_clk   (i_clk),
        .i_off   (r_s1_off_u[23:0]),
        .i_step  (step_eff),
        .o_quot  (q_u),
        .o_exact (ex_u)
    );

    lgbl_div u_div_g (
        .i_clk   (i_clk),
        .i_off   (r_s1_off_g[23:0]),
        .i_step  (step_eff),
        .o_quot  (q_g),
        .o_exact (ex_g)
    );

    logic  r_ln_vld [DIV_LAT];
    t_side r_ln     [DIV_LAT];

    always_ff @(posedge i_clk) begin
        r_ln[0] <= s1_side;
        for (int t = 1; t < DIV_LAT; t++) begin
            r_ln[t] <= r_ln[t-1];
        end
    end

    // Index stage.
    logic             r_ix_valid;
    t_side            r_ix;
    logic [ROW_W-1:0] r_ix_ru;
    logic [COL_W-1:0] r_ix_cg;
    logic [W_W-1:0]   r_ix_tx;
    logic [W_W-1:0]   r_ix_ty;
    t_loc             loc_u;
    t_loc             loc_g;

    always_comb begin
        loc_u = locate(q_u, ex_u);
        loc_g = locate(q_g, ex_g);
    end

    always_ff @(posedge i_clk) begin
        r_ix    <= r_ln[DIV_LAT-1];
        r_ix_ru <= loc_u.idx;
        r_ix_cg <= loc_g.idx[COL_W-1:0];
        r_ix_ty <= loc_u.w;
        r_ix_tx <= loc_g.w;
    end

    // Table stage: a write and a query never share a cycle here, so no
    // forwarding is needed.
    logic signed [VAL_W-1:0] f00;
    logic signed [VAL_W-1:0] f01;
    logic signed [VAL_W-1:0] f10;
    logic signed [VAL_W-1:0] f11;

    lgbl_table u_table (
        .i_clk      (i_clk),
        .i_we       (r_ix_valid && (r_ix.cmd == CMD_WRITE)),
        .i_wr_row   (r_ix.row),
        .i_wr_col   (r_ix.col),
        .i_wr_value (r_ix.value),
        .i_rd_row   (r_ix_ru),
        .i_rd_col   (r_ix_cg),
        .o_f00      (f00),
        .o_f01      (f01),
        .o_f10      (f10),
        .o_f11      (f11)
    );

    logic           r_mm_valid;
    logic           r_mm_oor;
    logic [W_W-1:0] r_mm_tx;
    logic [W_W-1:0] r_mm_ty;

    always_ff @(posedge i_clk) begin
        r_mm_oor <= r_ix.oor;
        r_mm_tx  <= r_ix_tx;
        r_mm_ty  <= r_ix_ty;
    end

    // Blend along gamma squared first, then along u.
    logic               r_m1_valid;
    logic               r_m1_oor;
    logic [W_W-1:0]     r_m1_ty;
    logic signed [41:0] r_p00;
    logic signed [41:0] r_p01;
    logic signed [41:0] r_p10;
    logic signed [41:0] r_p11;
    logic               r_a1_valid;
    logic               r_a1_oor;
    logic [W_W-1:0]     r_a1_ty;
    logic signed [42:0] r_a0;
    logic signed [42:0] r_a1;
    logic               r_m2_valid;
    logic               r_m2_oor;
    logic signed [60:0] r_q0;
    logic signed [60:0] r_q1;
    logic               r_a2_valid;
    logic               r_a2_oor;
    logic signed [23:0] r_a2_log;
    logic signed [61:0] acc;

    always_comb begin
        acc = 62'(r_q0) + 62'(r_q1) + 62'sd2147483648;
    end

    always_ff @(posedge i_clk) begin
        r_m1_oor <= r_mm_oor;
        r_m1_ty  <= r_mm_ty;
        r_p00    <= f00 * $signed({1'b0, W_ONE - r_mm_tx});
        r_p01    <= f01 * $signed({1'b0, r_mm_tx});
        r_p10    <= f10 * $signed({1'b0, W_ONE - r_mm_tx});
        r_p11    <= f11 * $signed({1'b0, r_mm_tx});
        r_a1_oor <= r_m1_oor;
        r_a1_ty  <= r_m1_ty;
        r_a0     <= 43'(r_p00) + 43'(r_p01);
        r_a1     <= 43'(r_p10) + 43'(r_p11);
        r_m2_oor <= r_a1_oor;
        r_q0     <= r_a0 * $signed({1'b0, W_ONE - r_a1_ty});
        r_q1     <= r_a1 * $signed({1'b0, r_a1_ty});
        r_a2_oor <= r_m2_oor;
        // The weights sum to 2^32, so the rounded blend fits 24 bits.
        r_a2_log <= acc[55:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_ix_valid <= 1'b0;
            r_mm_valid <= 1'b0;
            r_m1_valid <= 1'b0;
            r_a1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
            r_a2_valid <= 1'b0;
            for (int t = 0; t < DIV_LAT; t++) begin
                r_ln_vld[t] <= 1'b0;
            end
        end else begin
            r_s0_valid  <= i_start && !o_busy;
            r_s1_valid  <= r_s0_valid;
            r_ln_vld[0] <= r_s1_valid;
            for (int t = 1; t < DIV_LAT; t++) begin
                r_ln_vld[t] <= r_ln_vld[t-1];
            end
            r_ix_valid <= r_ln_vld[DIV_LAT-1];
            r_mm_valid <= r_ix_valid && (r_ix.cmd == CMD_QUERY);
            r_m1_valid <= r_mm_valid;
            r_a1_valid <= r_m1_valid;
            r_m2_valid <= r_a1_valid;
            r_a2_valid <= r_m2_valid;
        end
    end

    lgbl_exp u_exp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_a2_valid),
        .i_oor    (r_a2_oor),
        .i_log    (r_a2_log),
        .o_valid  (o_done),
        .o_result (o_result)
    );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for log_grid_bilinear_gaunt_lookup_core
// The table is first loaded at every entry that a query can reach. A directed
// table of commands and then random commands run under several register
// settings. The bench predicts each query result from its own copy of the
// table and registers, or takes it from the directed table, and compares the results in order.
// ----------------------------------------------------------------------------
module testbench;
    import lgbl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int  DRAIN_CYCLES = 70;
    localparam int  ITEM_W = $bits(t_item);
    localparam longint V_MIN = -8388608;
    localparam longint V_MAX = 8388607;

    typedef struct {
        t_item   it;
        bit      known;
        t_result res;
    } t_vec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    t_item       i_item = '0;
    logic        i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;
    logic        o_busy, o_done, o_cfg_ready;
    t_result     o_result;

    logic signed [23:0] log_tab [0:MAX_U_POINTS*MAX_G2_POINTS-1];
    longint  sh_g2_min, sh_u_min, sh_step, sh_u_pts, sh_g2_pts;
    t_result gaunt_q[$];
    int      n_errors = 0;

    log_grid_bilinear_gaunt_lookup_core dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #(24_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (gaunt_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("Unexpected result %h/%b", o_result.gaunt_value,
                             o_result.out_of_range);
            end else begin
                t_result exp_r;
                exp_r = gaunt_q.pop_front();
                if (o_result.gaunt_value !== exp_r.gaunt_value ||
                    o_result.out_of_range !== exp_r.out_of_range) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("Mismatch: expected %h/%b, got %h/%b",
                                 exp_r.gaunt_value, exp_r.out_of_range,
                                 o_result.gaunt_value, o_result.out_of_range);
                end
            end
        end
    end

    function automatic longint clamp_pts(longint n, longint maxn);
        if (n < 2) return 2;
        if (n > maxn) return maxn;
        return n;
    endfunction

    function automatic longint clip24(longint v);
        if (v < V_MIN) return V_MIN;
        if (v > V_MAX) return V_MAX;
        return v;
    endfunction

    function automatic longint eff_step();
        return (sh_step == 0) ? 1 : sh_step;
    endfunction

    // Fixed-point exp of a Q.16 value via 2^k * exp(frac*ln2).
    function automatic logic [23:0] exp_q16(longint l);
        longint y, k, sh;
        longint unsigned f, r, e, res;
        y = (l * 64'sd1549082005) >>> 14;
        k = y >>> 32;
        f = longint'(y - (k <<< 32));
        r = (f * 64'd744261118) >> 32;
        e = 64'd1 << 30;
        for (int n = 9; n >= 1; n--)
            e = (64'd1 << 30) + ((e * r) >> 30) / longint'(n);
        if (k >= 8) return MASK24;
        sh = 14 - k;
        if (sh >= 63) return 24'd0;
        res = (e + (64'd1 << (sh - 1))) >> sh;
        return (res > 64'hFF_FFFF) ? MASK24 : res[23:0];
    endfunction

    function automatic void find_cell(longint x, longint lo, longint stp, longint pts,
                                      output longint up, output longint w);
        longint base;
        up = (x - lo + stp - 1) / stp;
        if (up < 1) up = 1;
        if (up > pts - 1) up = pts - 1;
        base = lo + stp * (up - 1);
        w = ((x - base) * 65536) / stp;
    endfunction

    function automatic t_result predict_gaunt(t_item it);
        t_result rs;
        longint stp, nu, ng, xu, xg, ru, cg, ty, tx, acc;
        longint f00, f01, f10, f11;
        stp = eff_step();
        nu = clamp_pts(sh_u_pts, MAX_U_POINTS);
        ng = clamp_pts(sh_g2_pts, MAX_G2_POINTS);
        xu = it.log_u;
        xg = it.log_gamma2;
        rs = '0;
        if (xu < sh_u_min || xu > sh_u_min + (nu - 1) * stp ||
            xg < sh_g2_min || xg > sh_g2_min + (ng - 1) * stp) begin
            rs.out_of_range = 1'b1;
            return rs;
        end
        find_cell(xu, sh_u_min, stp, nu, ru, ty);
        find_cell(xg, sh_g2_min, stp, ng, cg, tx);
        f00 = log_tab[(ru - 1) * MAX_G2_POINTS + cg - 1];
        f01 = log_tab[(ru - 1) * MAX_G2_POINTS + cg];
        f10 = log_tab[ru * MAX_G2_POINTS + cg - 1];
        f11 = log_tab[ru * MAX_G2_POINTS + cg];
        acc = f00 * ((65536 - tx) * (65536 - ty)) + f01 * (tx * (65536 - ty))
            + f10 * ((65536 - tx) * ty) + f11 * (tx * ty);
        acc = (acc + 64'sd2147483648) >>> 32;
        rs.gaunt_value = exp_q16(acc);
        return rs;
    endfunction

    // A query is safe when it is out of range or its cell lies in the first
    // cells or at the far end of both axes, where the table is loaded.
    function automatic bit query_safe(t_item it);
        longint stp, nu, ng, iu, ig;
        bit     in_u, in_g;
        stp = eff_step();
        nu = clamp_pts(sh_u_pts, MAX_U_POINTS);
        ng = clamp_pts(sh_g2_pts, MAX_G2_POINTS);
        in_u = it.log_u >= sh_u_min && it.log_u <= sh_u_min + (nu - 1) * stp;
        in_g = it.log_gamma2 >= sh_g2_min && it.log_gamma2 <= sh_g2_min + (ng - 1) * stp;
        if (!in_u || !in_g) return 1'b1;
        iu = (it.log_u - sh_u_min + stp - 1) / stp;
        ig = (it.log_gamma2 - sh_g2_min + stp - 1) / stp;
        return (iu <= 7 || iu >= nu - 1) && (ig <= 7 || ig >= ng - 1);
    endfunction

    // Drives one command, waits for its transaction and records its effect.
    task automatic send_cmd(t_item it, bit known, t_result res, bit gaps);
        @(negedge i_clk);
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
        if (it.command == CMD_WRITE)
            log_tab[{it.entry_row, it.entry_col}] = it.entry_value;
        else
            gaunt_q.push_back(known ? res : predict_gaunt(it));
        if (gaps && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        int guard;
        @(negedge i_clk);
        i_start <= 1'b0;
        guard = 0;
        while (gaunt_q.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[23:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_G2_MIN: sh_g2_min = longint'($signed(val[23:0]));
            CFG_U_MIN:  sh_u_min  = longint'($signed(val[23:0]));
            CFG_STEP:   sh_step   = val[22:0];
            CFG_U_PTS:  sh_u_pts  = val[8:0];
            CFG_G2_PTS: sh_g2_pts = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(longint g2_min, longint u_min, longint stp,
                            longint u_pts, longint g2_pts);
        wait_idle();
        write_reg(CFG_G2_MIN, g2_min);
        write_reg(CFG_U_MIN, u_min);
        write_reg(CFG_STEP, stp);
        write_reg(CFG_U_PTS, u_pts);
        write_reg(CFG_G2_PTS, g2_pts);
        write_reg(CFG_UNUSED, $urandom);
    endtask

    // In-range picks stay within the first cells or at the far end.
    function automatic longint pick_coord(longint lo, longint pts);
        longint stp, hi, span, nlim, lim;
        stp = eff_step();
        hi = lo + (clamp_pts(pts, 1 << 30) - 1) * stp;
        if (hi > V_MAX) hi = V_MAX;
        span = hi - lo + 1;
        nlim = span / stp + 1;
        if (nlim > 7) nlim = 7;
        lim = span;
        if (lim > 7 * stp) lim = 7 * stp;
        case ($urandom_range(0, 9))
            0: return lo;
            1: return hi;
            2: return clip24(lo - 1);
            3: return clip24(hi + 1);
            4, 5: return clip24(lo + stp * longint'({$urandom, $urandom} % nlim));
            default: return lo + longint'({$urandom, $urandom} % lim);
        endcase
    endfunction

    function automatic logic [23:0] rand_log();
        if ($urandom_range(0, 4) == 0) return 24'($urandom);
        return 24'($urandom_range(0, 12 * 65536) - 6 * 65536);
    endfunction

    task automatic run_random(int count, bit gaps);
        t_item  it;
        longint cu, cg;
        for (int i = 0; i < count; i++) begin
            it = ITEM_W'({$urandom, $urandom, $urandom});
            if ($urandom_range(0, 99) < 30) begin
                it.command = CMD_WRITE;
                it.entry_value = rand_log();
            end else begin
                it.command = CMD_QUERY;
                if ($urandom_range(0, 99) < 85 || !query_safe(it)) begin
                    cu = pick_coord(sh_u_min, clamp_pts(sh_u_pts, MAX_U_POINTS));
                    cg = pick_coord(sh_g2_min, clamp_pts(sh_g2_pts, MAX_G2_POINTS));
                    it.log_u = cu[23:0];
                    it.log_gamma2 = cg[23:0];
                end
            end
            send_cmd(it, 1'b0, '0, gaps);
        end
    endtask

    function automatic t_vec mk(logic cmd, int row, int col, longint val,
                                longint lu, longint lg, bit known,
                                logic [23:0] gv, logic oor);
        t_vec v;
        v.it = '0;
        v.it.command = cmd;
        v.it.entry_row = ROW_W'(row);
        v.it.entry_col = COL_W'(col);
        v.it.entry_value = val[23:0];
        v.it.log_u = lu[23:0];
        v.it.log_gamma2 = lg[23:0];
        v.known = known;
        v.res.gaunt_value = gv;
        v.res.out_of_range = oor;
        return v;
    endfunction

    initial begin
        t_vec   dir_tab[$];
        t_item  it;
        longint lu0, lg0, hu0, hg0;
        int     ld_rows [12];
        int     ld_cols [12];

        sh_g2_min = -393216;
        sh_u_min  = -1048576;
        sh_step   = 13107;
        sh_u_pts  = 146;
        sh_g2_pts = 81;
        lu0 = sh_u_min;
        lg0 = sh_g2_min;
        hu0 = lu0 + 145 * 13107;
        hg0 = lg0 + 80 * 13107;
        ld_rows = '{0, 1, 2, 3, 4, 5, 6, 7, 144, 145, 254, 255};
        ld_cols = '{0, 1, 2, 3, 4, 5, 6, 7, 79, 80, 126, 127};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Load the first cells and the far-end cells of every grid used
        // below, so that no query can reach an unwritten entry.
        foreach (ld_rows[r]) begin
            foreach (ld_cols[c]) begin
                it = ITEM_W'({$urandom, $urandom, $urandom});
                it.command = CMD_WRITE;
                it.entry_row = ROW_W'(ld_rows[r]);
                it.entry_col = COL_W'(ld_cols[c]);
                it.entry_value = rand_log();
                send_cmd(it, 1'b0, '0, 1'b0);
            end
        end

        dir_tab.push_back(mk(CMD_WRITE, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(CMD_QUERY, 0, 0, 0, lu0, lg0, 1, 24'd65536, 0));
        dir_tab.push_back(mk(CMD_WRITE, 0, 0, V_MAX, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(CMD_QUERY, 0, 0, 0, lu0, lg0, 1, MASK24, 0));
        dir_tab.push_back(mk(CMD_WRITE, 0, 0, V_MIN, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(CMD_QUERY, 0, 0, 0, lu0, lg0, 1, 24'd0, 0));
        dir_tab.push_back(mk(CMD_QUERY, 0, 0, 0, hu0, hg0, 0, 0, 0));
        dir_tab.push_back(mk(CMD_QUERY, 0, 0, 0, lu0 - 1, lg0, 1, 24'd0, 1));
        dir_tab.push_back(mk(CMD_QUERY, 0, 0, 0, hu0 + 1, lg0, 1, 24'd0, 1));
        dir_tab.push_back(mk(CMD_QUERY, 0, 0, 0, lu0, lg0 - 1, 1, 24'd0, 1));
        dir_tab.push_back(mk(CMD_QUERY, 0, 0, 0, lu0, hg0 + 1, 1, 24'd0, 1));
        dir_tab.push_back(mk(CMD_QUERY, 0, 0, 0, V_MIN, V_MIN, 1, 24'd0, 1));
        dir_tab.push_back(mk(CMD_QUERY, 0, 0, 0, V_MAX, V_MAX, 1, 24'd0, 1));
        dir_tab.push_back(mk(CMD_WRITE, 255, 127, V_MAX, V_MIN, V_MAX, 0, 0, 0));
        dir_tab.push_back(mk(CMD_WRITE, 1, 1, -65536, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(CMD_QUERY, 0, 0, 0, lu0 + 6553, lg0 + 6553, 0, 0, 0));
        dir_tab.push_back(mk(CMD_QUERY, 0, 0, 0, lu0 + 13107, lg0 + 13107, 0, 0, 0));
        dir_tab.push_back(mk(CMD_QUERY, 0, 0, 0, lu0 + 13108, lg0 + 1, 0, 0, 0));
        dir_tab.push_back(mk(CMD_QUERY, 0, 0, 0, hu0 - 1, hg0 - 1, 0, 0, 0));
        foreach (dir_tab[i])
            send_cmd(dir_tab[i].it, dir_tab[i].known, dir_tab[i].res, 1'b1);
        run_random(60, 1'b1);

        // Smallest grid, zero step, mins at both extremes.
        set_grid(V_MAX, V_MIN, 0, 2, 2);
        run_random(40, 1'b1);
        // Largest step, point counts above the maximum.
        set_grid(V_MIN, V_MIN, 23'h7F_FFFF, 511, 255);
        run_random(40, 1'b1);
        // Point counts below the minimum.
        set_grid(0, 0, 65536, 0, 1);
        run_random(40, 1'b1);
        // Full-size grid whose far end stays inside the input range.
        set_grid($signed(24'($urandom_range(0, 400000))) - 200000,
                 $signed(24'($urandom_range(0, 400000))) - 200000,
                 $urandom_range(1000, 32000), 256, 128);
        run_random(60, 1'b1);
        // Back to the reset grid, with no gaps.
        set_grid(-393216, -1048576, 13107, 146, 81);
        run_random(60, 1'b0);

        wait_idle();
        n_errors += gaunt_q.size();
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* log_grid_bilinear_gaunt_lookup_core.f */
rtl/lgbl_pkg.sv
rtl/lgbl_div.sv
rtl/lgbl_table.sv
rtl/lgbl_exp.sv
rtl/log_grid_bilinear_gaunt_lookup_core.sv
test/testbench.sv
